[hw/rtl/sbd_pkg.sv]
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared types and constants of the secant boundary distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package sbd_pkg;

  // level set and secant step values: signed, fixed point
  localparam int ACC_W = 62;
  // quotient bits kept by the divider before saturation
  localparam int QUO_W = ACC_W - 1;
  localparam int DIST_W = 33;
  localparam int ITER_W = 6;
  localparam int TOL_W = 20;
  localparam int RAD_W = 31;
  localparam int CFG_W = 31;
  localparam int CFG_IDX_W = 2;
  localparam int IN_FIELD_W = 32;
  localparam int IN_DATA_W = 4 * IN_FIELD_W;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;

  localparam logic [ITER_W-1:0] ITER_CAP = 6'd62;
  localparam logic [ITER_W-1:0] ITER_RESET = 6'd30;
  localparam logic [RAD_W-1:0] RAD_RESET = 31'd268435456;
  localparam logic [63:0] DIST_MAX = (64'd1 << DIST_W) - 64'd1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ = 2'd2;

  // shared unit operations
  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_DIV = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } unit_req_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } unit_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/sbd_unit.sv]
// ----------------------------------------------------------------------------
// sbd_unit
// Shared iterative unit: shift-add multiply, restoring divide and digit
// square root, all on one add/subtract datapath, one step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sbd_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  sbd_pkg::unit_req_t                      req,
  input  logic [sbd_pkg::ACC_W-1:0]               opa,
  input  logic [sbd_pkg::ACC_W+COORD_WIDTH:0]     opb,
  output sbd_pkg::unit_rsp_t                      rsp,
  output logic [sbd_pkg::ACC_W+COORD_WIDTH:0]     prod,
  output logic [sbd_pkg::QUO_W-1:0]               quo
);
  import sbd_pkg::*;

  localparam int AW = ACC_W;
  localparam int BW = COORD_WIDTH + 1;
  localparam int PW = AW + BW;
  localparam int SW = 2 * BW;
  localparam int QB = QUO_W;
  localparam int RW = ACC_W + 1;
  localparam int UW = RW;
  localparam int CNT_W = $clog2(QB + 2);

  logic             busy;
  logic             done;
  logic             ovf;
  logic [1:0]       op;
  logic [CNT_W-1:0] cnt;
  logic [AW-1:0]    a;
  logic [PW-1:0]    p;
  logic [RW-1:0]    r;
  logic [QB-1:0]    q;

  logic [RW-1:0]    rsh;
  logic [BW+1:0]    rsq;
  logic [UW-1:0]    x;
  logic [UW-1:0]    y;
  logic             sub;
  logic [UW:0]      sum;
  logic             ge;
  logic             last;

  always_comb begin
    rsh = (cnt == '0) ? r : {r[RW-2:0], p[QB-1]};
    rsq = {r[BW-1:0], p[SW-1:SW-2]};
    x   = '0;
    y   = '0;
    sub = 1'b0;
    case (op)
      OP_MUL: begin
        x = UW'(p[PW-1:BW]);
        y = p[0] ? UW'(a) : '0;
      end
      OP_DIV: begin
        x   = rsh;
        y   = UW'(a);
        sub = 1'b1;
      end
      OP_SQRT: begin
        x   = UW'(rsq);
        y   = UW'({q[BW-1:0], 2'b01});
        sub = 1'b1;
      end
      default: begin
        x = '0;
      end
    endcase
    sum = {1'b0, x} + {1'b0, y ^ {UW{sub}}} + (UW+1)'(sub);
    ge  = sum[UW];
    case (op)
      OP_MUL:  last = (cnt == CNT_W'(BW - 1));
      OP_DIV:  last = (cnt == CNT_W'(QB)) || ((cnt == '0) && ge);
      OP_SQRT: last = (cnt == CNT_W'(BW - 1));
      default: last = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op  <= req.op;
      cnt <= '0;
      a   <= opa;
      p   <= opb;
      q   <= '0;
      ovf <= 1'b0;
      r   <= (req.op == OP_DIV) ? RW'(opb[PW-1:QB]) : '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      case (op)
        OP_MUL: begin
          p <= {sum[AW:0], p[BW-1:1]};
        end
        OP_DIV: begin
          if (cnt == '0) begin
            // quotient would need more bits than a step value holds
            ovf <= ge;
          end else begin
            r <= ge ? sum[RW-1:0] : rsh;
            p <= {p[PW-2:0], 1'b0};
            q <= {q[QB-2:0], ge};
          end
        end
        OP_SQRT: begin
          r <= ge ? RW'(sum[BW+1:0]) : RW'(rsq);
          p <= {p[PW-3:0], 2'b00};
          q <= {q[QB-2:0], ge};
        end
        default: begin
          p <= p;
        end
      endcase
    end
  end

  assign rsp  = '{done: done, ovf: ovf};
  assign prod = p;
  assign quo  = q;

endmodule

`default_nettype wire

[hw/rtl/secant_boundary_distance.sv]
// ----------------------------------------------------------------------------
// secant_boundary_distance
// Secant search for the circle crossing between an interior point and a
// ghost point, returning the distance from the interior point to the root.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries x_inside, x_outside, y_inside, y_outside (32 bit each,
//   signed Q3.28) and s_tuser the search axis. One beat in gives one beat
//   out: m_tdata holds distance and iterations_used, m_tuser the converged
//   and divide_fault flags. The user must write the registers on cfg_wen
//   only while idle; the block itself does not enforce this. All arithmetic
//   runs on one shared multiply/divide/root unit, one step a cycle. Each
//   secant iteration evaluates the level set at the new guess and runs
//   one multiply and one divide per axis; the search ends with two
//   squarings and a square root for the distance. s_tready is high only
//   while idle.
//   The result sits in an output register; the next beat can be accepted
//   while it waits, and the sequencer holds in its last state if the
//   previous result has not been taken. Reset puts the sequencer idle,
//   drops m_tvalid and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module secant_boundary_distance #(
  parameter int FRAC_BITS = 28,
  parameter int COORD_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wen,
  input  logic [sbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sbd_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // x_inside, x_outside, y_inside, y_outside
  input  logic [sbd_pkg::IN_DATA_W-1:0]      s_tdata,
  // direction
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // distance, iterations_used, zero pad
  output logic [sbd_pkg::OUT_DATA_W-1:0]     m_tdata,
  // converged, divide_fault
  output logic [sbd_pkg::OUT_USER_W-1:0]     m_tuser
);
  import sbd_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int BW = CW + 1;
  localparam int AW = ACC_W;
  localparam int PW = AW + BW;
  localparam int SW = 2 * BW;

  localparam logic signed [63:0] CMAX = (64'sd1 <<< (CW - 1)) - 64'sd1;
  localparam logic signed [63:0] CMIN = -CMAX - 64'sd1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LVX   = 4'd1;
  localparam logic [3:0] S_LVY   = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_DEN   = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_UPD   = 4'd7;
  localparam logic [3:0] S_DX    = 4'd8;
  localparam logic [3:0] S_DY    = 4'd9;
  localparam logic [3:0] S_SQRT  = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  function automatic logic signed [CW-1:0] sat_in(input logic [IN_FIELD_W-1:0] v);
    logic signed [63:0] w;
    w = 64'(signed'(v));
    if (w > CMAX) return CMAX[CW-1:0];
    if (w < CMIN) return CMIN[CW-1:0];
    return w[CW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] sat_co(input logic signed [AW:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    if (w > CMAX) return CMAX[CW-1:0];
    if (w < CMIN) return CMIN[CW-1:0];
    return w[CW-1:0];
  endfunction

  function automatic logic [BW-1:0] mag_c(input logic signed [CW-1:0] v);
    logic signed [BW-1:0] e;
    e = BW'(v);
    return e[BW-1] ? BW'(-e) : BW'(e);
  endfunction

  function automatic logic [AW-1:0] mag_a(input logic signed [AW-1:0] v);
    return v[AW-1] ? AW'(-v) : AW'(v);
  endfunction

  logic [TOL_W-1:0]  tolerance;
  logic [ITER_W-1:0] max_iterations;
  logic [RAD_W-1:0]  radius_squared;

  logic [3:0] state;
  logic       issued;

  logic signed [CW-1:0] xi, yi, xn, yn, xp, yp, nx, ny, lx, ly;
  logic signed [AW-1:0] fn, fprev, den;
  logic [AW-2:0]        sqx;
  logic [SW-1:0]        vsum;
  logic [ITER_W-1:0]    cnt;
  logic                 first, to_prev, fault, axis;
  logic [DIST_W-1:0]    hit_len;

  unit_req_t        req;
  unit_rsp_t        rsp;
  logic [AW-1:0]    opa;
  logic [PW-1:0]    opb;
  logic [PW-1:0]    prod;
  logic [QUO_W-1:0] quo;

  logic [PW-1:0]        sh;
  logic [AW-2:0]        sq_sat;
  logic [AW-1:0]        sq_sum;
  logic signed [AW-1:0] lv;
  logic signed [AW:0]   den_w;
  logic signed [AW-1:0] den_c;
  logic signed [BW-1:0] dxv;
  logic [AW-1:0]        mag_fn;
  logic                 step_neg;
  logic signed [AW-1:0] step;
  logic signed [AW:0]   newc_w;
  logic signed [CW-1:0] newc;
  logic [ITER_W-1:0]    limit;
  logic                 more;
  logic [63:0]          root64;
  logic                 out_free;

  sbd_unit #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_unit (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .opa  (opa),
    .opb  (opb),
    .rsp  (rsp),
    .prod (prod),
    .quo  (quo)
  );

  always_comb begin
    // floored square, saturated to the positive step range
    sh     = prod >> FRAC_BITS;
    sq_sat = (|sh[PW-1:AW-1]) ? {(AW-1){1'b1}} : sh[AW-2:0];
    sq_sum = {1'b0, sqx} + {1'b0, sq_sat};
    lv     = signed'(sq_sum[AW-1] ? {1'b0, {(AW-1){1'b1}}} : sq_sum)
             - signed'(AW'(radius_squared));

    den_w = (AW+1)'(fn) - (AW+1)'(fprev);
    if (den_w[AW] != den_w[AW-1]) den_c = den_w[AW] ? ACC_MIN : ACC_MAX;
    else den_c = den_w[AW-1:0];

    dxv    = axis ? (BW'(yn) - BW'(yp)) : (BW'(xn) - BW'(xp));
    mag_fn = mag_a(fn);

    step_neg = fn[AW-1] ^ dxv[BW-1] ^ den[AW-1];
    if (rsp.ovf) step = step_neg ? ACC_MIN : ACC_MAX;
    else step = step_neg ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
    newc_w = (axis ? (AW+1)'(yn) : (AW+1)'(xn)) - (AW+1)'(step);
    newc   = sat_co(newc_w);

    limit = (max_iterations > ITER_CAP) ? ITER_CAP : max_iterations;
    more  = (mag_fn > AW'(tolerance)) && (cnt <= limit);

    root64   = 64'(quo[BW-1:0]);
    out_free = !m_tvalid || m_tready;
    s_tready = (state == S_IDLE);

    req.start = 1'b0;
    req.op    = OP_MUL;
    opa       = '0;
    opb       = '0;
    case (state)
      S_LVX: begin
        req.start = !issued;
        opa       = AW'(mag_c(lx));
        opb       = PW'(mag_c(lx));
      end
      S_LVY: begin
        req.start = !issued;
        opa       = AW'(mag_c(ly));
        opb       = PW'(mag_c(ly));
      end
      S_MUL: begin
        req.start = !issued;
        opa       = mag_fn;
        opb       = PW'(dxv[BW-1] ? BW'(-dxv) : BW'(dxv));
      end
      S_DIV: begin
        req.start = !issued;
        req.op    = OP_DIV;
        opa       = mag_a(den);
        opb       = prod;
      end
      S_DX: begin
        req.start = !issued;
        opa       = AW'(((BW'(xn) - BW'(xi)) >> (BW - 1)) != 0
                    ? BW'(-(BW'(xn) - BW'(xi))) : BW'(BW'(xn) - BW'(xi)));
        opb       = PW'(opa);
      end
      S_DY: begin
        req.start = !issued;
        opa       = AW'(((BW'(yn) - BW'(yi)) >> (BW - 1)) != 0
                    ? BW'(-(BW'(yn) - BW'(yi))) : BW'(BW'(yn) - BW'(yi)));
        opb       = PW'(opa);
      end
      S_SQRT: begin
        req.start = !issued;
        req.op    = OP_SQRT;
        opb       = PW'(vsum);
      end
      default: begin
        req.start = 1'b0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance      <= '0;
      max_iterations <= ITER_RESET;
      radius_squared <= RAD_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_TOLERANCE: tolerance      <= cfg_data[TOL_W-1:0];
        REG_MAX_ITER:  max_iterations <= cfg_data[ITER_W-1:0];
        REG_RADIUS_SQ: radius_squared <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      issued   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (req.start) issued <= 1'b1;
      if (rsp.done) issued <= 1'b0;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE:  if (s_tvalid) state <= S_LVX;
        S_LVX:   if (rsp.done) state <= S_LVY;
        S_LVY:   if (rsp.done) state <= to_prev ? S_DEN : S_CHECK;
        S_CHECK: begin
          if (!more) state <= S_DX;
          else if (first) state <= S_LVX;
          else state <= S_DEN;
        end
        S_DEN:   state <= (den_c == '0) ? S_DX : S_MUL;
        S_MUL:   if (rsp.done) state <= S_DIV;
        S_DIV:   if (rsp.done) state <= axis ? S_UPD : S_MUL;
        S_UPD:   state <= S_LVX;
        S_DX:    if (rsp.done) state <= S_DY;
        S_DY:    if (rsp.done) state <= S_SQRT;
        S_SQRT:  if (rsp.done) state <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            state    <= S_IDLE;
            m_tvalid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          xi      <= sat_in(s_tdata[IN_FIELD_W-1:0]);
          yi      <= sat_in(s_tdata[3*IN_FIELD_W-1:2*IN_FIELD_W]);
          xn      <= sat_in(s_tdata[IN_FIELD_W-1:0]);
          yn      <= sat_in(s_tdata[3*IN_FIELD_W-1:2*IN_FIELD_W]);
          lx      <= sat_in(s_tdata[IN_FIELD_W-1:0]);
          ly      <= sat_in(s_tdata[3*IN_FIELD_W-1:2*IN_FIELD_W]);
          // second guess moves only along the search axis
          xp      <= s_tuser ? sat_in(s_tdata[IN_FIELD_W-1:0])
                             : sat_in(s_tdata[2*IN_FIELD_W-1:IN_FIELD_W]);
          yp      <= s_tuser ? sat_in(s_tdata[4*IN_FIELD_W-1:3*IN_FIELD_W])
                             : sat_in(s_tdata[3*IN_FIELD_W-1:2*IN_FIELD_W]);
          cnt     <= '0;
          fault   <= 1'b0;
          first   <= 1'b1;
          to_prev <= 1'b0;
        end
      end
      S_LVX: if (rsp.done) sqx <= sq_sat;
      S_LVY: begin
        if (rsp.done) begin
          if (to_prev) fprev <= lv;
          else fn <= lv;
        end
      end
      S_CHECK: begin
        if (more && first) begin
          first   <= 1'b0;
          to_prev <= 1'b1;
          lx      <= xp;
          ly      <= yp;
        end
      end
      S_DEN: begin
        den  <= den_c;
        axis <= 1'b0;
        if (den_c == '0) fault <= 1'b1;
      end
      S_DIV: begin
        if (rsp.done) begin
          if (axis) ny <= newc;
          else nx <= newc;
          axis <= 1'b1;
        end
      end
      S_UPD: begin
        xp      <= xn;
        yp      <= yn;
        xn      <= nx;
        yn      <= ny;
        lx      <= nx;
        ly      <= ny;
        fprev   <= fn;
        cnt     <= cnt + 1'b1;
        to_prev <= 1'b0;
      end
      S_DX:   if (rsp.done) vsum <= prod[SW-1:0];
      S_DY:   if (rsp.done) vsum <= vsum + prod[SW-1:0];
      S_SQRT: begin
        if (rsp.done) begin
          hit_len <= (root64 > DIST_MAX) ? {DIST_W{1'b1}} : root64[DIST_W-1:0];
        end
      end
      S_FIN: begin
        if (out_free) begin
          m_tdata <= OUT_DATA_W'({cnt, hit_len});
          m_tuser <= {fault, !(mag_fn > AW'(tolerance))};
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/sbd_checker.sv]
// ----------------------------------------------------------------------------
// sbd_checker
// Port level checks of the secant boundary distance block, bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

module sbd_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               s_tvalid,
  input wire logic                               s_tready,
  input wire logic                               m_tvalid,
  input wire logic                               m_tready,
  input wire logic [sbd_pkg::OUT_DATA_W-1:0]     m_tdata,
  input wire logic [sbd_pkg::OUT_USER_W-1:0]     m_tuser
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("not idle after reset");

  // the block works on one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again straight after a beat");

  // a divide fault stops the search before convergence
  a_fault_not_conv: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("converged and divide fault both set");

endmodule

bind secant_boundary_distance sbd_checker u_sbd_checker (.*);

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the secant boundary distance block: directed corner
// items, register sweeps, random geometry with idling on both sides and a
// long output stall; every result is checked against a predictor in the tb.
// ----------------------------------------------------------------------------
module tb;
  import sbd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam longint ONE = 64'sd1 << 28;
  localparam longint AMAX = (64'sd1 << 61) - 1;
  localparam longint AMIN = -AMAX - 1;
  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -CMAX - 1;
  localparam int STALL_LIMIT = 200000;

  typedef struct {
    logic [32:0] distance;
    logic [5:0]  iterations;
    logic        converged;
    logic        div_fault;
  } boundary_hit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;

  boundary_hit_t pending_hits[$];
  int errors = 0;
  int stall_count = 0;
  int hold_request = 0;
  int hold_left = 0;
  bit quiet = 1'b0;
  longint tol_reg, iter_reg, rad_reg;

  secant_boundary_distance dut (.*);

  always #1 clk = ~clk;

  // ---------------- predictor ----------------
  function automatic longint magn(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint clamp_acc(longint v);
    return v > AMAX ? AMAX : (v < AMIN ? AMIN : v);
  endfunction

  function automatic longint clamp_coord(longint v);
    return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
  endfunction

  function automatic longint square_fx(longint v);
    logic [127:0] p;
    p = ({64'd0, magn(v)} * {64'd0, magn(v)}) >> 28;
    return p > AMAX ? AMAX : longint'(p[63:0]);
  endfunction

  function automatic longint level_fx(longint x, longint y);
    return clamp_acc(clamp_acc(square_fx(x) + square_fx(y)) - rad_reg);
  endfunction

  function automatic longint secant_step(longint num, longint dx, longint den);
    logic [127:0] n, q;
    logic [63:0] d;
    bit neg;
    neg = ((num < 0) != (dx < 0)) != (den < 0);
    d = magn(den);
    n = {64'd0, magn(num)} * {64'd0, magn(dx)};
    if (n[127:64] >= d) return neg ? AMIN : AMAX;
    q = n / {64'd0, d};
    if (q > AMAX) return neg ? AMIN : AMAX;
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic boundary_hit_t predict_hit(longint xi, longint xo, longint yi,
                                                longint yo, bit dir);
    boundary_hit_t h;
    longint xp, yp, xn, yn, fn, den, nx, ny, lim, cnt;
    logic [127:0] sum;
    logic [63:0] root, t;
    bit fault;
    lim = iter_reg > 62 ? 62 : iter_reg;
    cnt = 0;
    fault = 1'b0;
    xn = xi;
    yn = yi;
    xp = dir ? xi : xo;
    yp = dir ? yo : yi;
    fn = level_fx(xn, yn);
    while (magn(fn) > tol_reg && cnt <= lim) begin
      den = clamp_acc(fn - level_fx(xp, yp));
      if (den == 0) begin
        fault = 1'b1;
        break;
      end
      nx = clamp_coord(xn - secant_step(fn, xn - xp, den));
      ny = clamp_coord(yn - secant_step(fn, yn - yp, den));
      xp = xn;
      yp = yn;
      xn = nx;
      yn = ny;
      cnt++;
      fn = level_fx(xn, yn);
    end
    sum = {64'd0, magn(xn - xi)} * {64'd0, magn(xn - xi)}
        + {64'd0, magn(yn - yi)} * {64'd0, magn(yn - yi)};
    root = 0;
    for (int b = 40; b >= 0; b--) begin
      t = root | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= sum) root = t;
    end
    h.distance = root > DIST_MAX ? DIST_MAX[32:0] : root[32:0];
    h.iterations = cnt[5:0];
    h.converged = magn(fn) <= tol_reg;
    h.div_fault = fault;
    return h;
  endfunction

  // ---------------- result side ----------------
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet || $urandom_range(0, 99) >= 22;
    end
  end

  always @(posedge clk) begin
    boundary_hit_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result beat tdata=%h tuser=%b", $time, m_tdata, m_tuser);
        errors++;
      end else begin
        e = pending_hits.pop_front();
        if (m_tdata[32:0] !== e.distance) begin
          $display("%0t: distance exp %h got %h", $time, e.distance, m_tdata[32:0]);
          errors++;
        end
        if (m_tdata[38:33] !== e.iterations) begin
          $display("%0t: iterations exp %0d got %0d", $time, e.iterations, m_tdata[38:33]);
          errors++;
        end
        if (m_tuser[0] !== e.converged) begin
          $display("%0t: converged exp %b got %b", $time, e.converged, m_tuser[0]);
          errors++;
        end
        if (m_tuser[1] !== e.div_fault) begin
          $display("%0t: divide_fault exp %b got %b", $time, e.div_fault, m_tuser[1]);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count > STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------- stimulus helpers ----------------
  task automatic send_point(longint xi, longint xo, longint yi, longint yo, bit dir);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < 22) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {yo[31:0], yi[31:0], xo[31:0], xi[31:0]};
    s_tuser = dir;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_hits.push_back(predict_hit(xi, xo, yi, yo, dir));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
    wait_drained();
    @(negedge clk);
    cfg_wen = 1'b1;
    cfg_index = idx;
    cfg_data = val[CFG_W-1:0];
    @(negedge clk);
    cfg_wen = 1'b0;
    case (idx)
      REG_TOLERANCE: tol_reg = val & 64'hFFFFF;
      REG_MAX_ITER:  iter_reg = val & 64'h3F;
      REG_RADIUS_SQ: rad_reg = val & 64'h7FFFFFFF;
      default: ;
    endcase
  endtask

  function automatic longint fx(real v);
    return longint'(v * 268435456.0);
  endfunction

  function automatic real rnd(real a, real b);
    return a + (b - a) * ($urandom / 4294967295.0);
  endfunction

  // inside point with a ghost point beyond the circle on the chosen axis
  task automatic send_crossing();
    real r, xi, yi, g;
    bit dir;
    r = $sqrt(rad_reg / 268435456.0);
    xi = r * rnd(-0.7, 0.7);
    yi = r * rnd(-0.7, 0.7);
    g = r + rnd(0.01, 0.6);
    if ($urandom_range(0, 1)) g = -g;
    dir = $urandom_range(0, 1);
    send_point(fx(xi), fx(g), fx(yi), fx(g), dir);
  endtask

  task automatic send_noise();
    send_point(longint'(int'($urandom)), longint'(int'($urandom)),
               longint'(int'($urandom)), longint'(int'($urandom)), $urandom_range(0, 1));
  endtask

  // ---------------- tests ----------------
  task automatic test_corner_points();
    send_point(0, 2 * ONE, 0, 0, 1'b0);
    send_point(0, 0, 0, 2 * ONE, 1'b1);
    send_point(ONE / 4, -3 * ONE, -ONE / 3, 5 * ONE, 1'b0);
    send_point(ONE / 2, ONE / 2, ONE / 2, 3 * ONE, 1'b0);     // zero denominator
    send_point(0, 0, 0, 0, 1'b1);                             // zero denominator
    send_point(ONE, 3 * ONE, 0, 0, 1'b0);                     // already on the circle
    send_point(CMAX, CMAX, CMAX, CMAX, 1'b0);
    send_point(CMIN, CMIN, CMIN, CMIN, 1'b1);
    send_point(CMIN, CMAX, CMAX, CMIN, 1'b0);
    send_point(CMAX, CMIN, CMIN, CMAX, 1'b1);
    send_point(0, CMIN, 0, CMAX, 1'b0);
  endtask

  task automatic test_register_extremes();
    write_reg(REG_TOLERANCE, 64'hFFFFF);
    send_point(ONE / 2, 2 * ONE, 0, 0, 1'b0);
    write_reg(REG_TOLERANCE, 0);
    write_reg(REG_MAX_ITER, 0);
    send_point(0, 2 * ONE, 0, 0, 1'b0);
    write_reg(REG_MAX_ITER, 63);                              // capped at 62
    send_point(ONE / 3, 2 * ONE, ONE / 5, 0, 1'b0);
    write_reg(REG_RADIUS_SQ, 0);
    send_point(ONE, 2 * ONE, ONE, 0, 1'b1);
    write_reg(REG_RADIUS_SQ, 64'h7FFFFFFF);
    send_point(0, 0, ONE, 3 * ONE, 1'b1);
    write_reg(REG_SPARE, 64'h7FFFFFFF);                       // ignored by the block
    send_point(ONE / 8, 2 * ONE, 0, 0, 1'b0);
    write_reg(REG_MAX_ITER, 30);
    write_reg(REG_RADIUS_SQ, ONE);
  endtask

  task automatic test_random_geometry(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(0, 3))
        0: write_reg(REG_TOLERANCE, 0);
        1: write_reg(REG_TOLERANCE, $urandom_range(0, 1048575));
        default: write_reg(REG_TOLERANCE, $urandom_range(1, 4096));
      endcase
      write_reg(REG_MAX_ITER, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                           : $urandom_range(0, 12));
      write_reg(REG_RADIUS_SQ, ($urandom_range(0, 7) == 0) ? longint'($urandom) & 64'h7FFFFFFF
                                                            : $urandom_range(1 << 25, 32'h7FFFFFFF));
      quiet = (p == 1);
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(0, 99) < 80) send_crossing();
        else send_noise();
      end
    end
    quiet = 1'b0;
  endtask

  task automatic test_output_stall();
    write_reg(REG_MAX_ITER, 4);
    write_reg(REG_TOLERANCE, 256);
    hold_request = 4000;
    for (int i = 0; i < 6; i++) send_crossing();
    wait_drained();
    write_reg(REG_MAX_ITER, 30);
  endtask

  initial begin
    tol_reg = 0;
    iter_reg = ITER_RESET;
    rad_reg = RAD_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_corner_points();
    test_register_extremes();
    test_output_stall();
    test_random_geometry(8, 45);
    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
